[rtl/scd_pkg.sv]
// Shared types and constants for the strip charge division position block.
`default_nettype none

package scd_pkg;

    // Configuration defaults
    localparam int NUM_DETECTORS_DEF = 12;
    localparam int NUM_STRIPS_DEF    = 4;
    localparam int ADC_BITS_DEF      = 12;
    localparam int TABLE_DEPTH_DEF   = 2 * NUM_DETECTORS_DEF * NUM_STRIPS_DEF;

    // Fixed field widths
    localparam int DET_W   = 4;
    localparam int STRIP_W = 3;
    localparam int ADC_W   = 12;
    localparam int CAL_W   = 16;
    localparam int ESUM_W  = 17;
    localparam int THR_W   = 16;
    localparam int ENTRY_W = 3 * CAL_W;

    localparam logic [THR_W-1:0] THRESH_RESET = 16'd1000;

    // Request codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_HIT  = 1'b1;

    // Divider geometry: 44-bit dividend magnitude, 30-bit divisor magnitude,
    // 16 quotient bits plus an overflow flag.
    localparam int DIV_NUM_W = 44;
    localparam int DIV_DEN_W = 30;
    localparam int DIV_Q_W   = 16;
    localparam int DIV_REM_W = DIV_DEN_W + DIV_Q_W;

    typedef struct packed {
        logic                 start;
        logic                 neg;
        logic [DIV_NUM_W-1:0] num_mag;
        logic [DIV_DEN_W-1:0] den_mag;
    } t_div_req;

    typedef struct packed {
        logic                     busy;
        logic                     done;
        logic signed [DIV_Q_W-1:0] quot;
    } t_div_rsp;

endpackage

`default_nettype wire

[rtl/scd_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module scd_ram #(
    parameter int WIDTH = scd_pkg::ENTRY_W,
    parameter int DEPTH = scd_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/scd_div.sv]
// Bit-serial restoring divider with sign fixup and 16-bit signed saturation.
`default_nettype none

module scd_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire scd_pkg::t_div_req i_req,
    output scd_pkg::t_div_rsp      o_rsp
);

    localparam int QW   = scd_pkg::DIV_Q_W;
    localparam int RW   = scd_pkg::DIV_REM_W;
    localparam int NW   = scd_pkg::DIV_NUM_W;
    localparam int DW   = scd_pkg::DIV_DEN_W;
    localparam int CntW = $clog2(QW);
    localparam logic [CntW-1:0] LastStep = CntW'(QW - 1);
    localparam logic [QW-1:0]   PosMax   = {1'b0, {(QW-1){1'b1}}};
    localparam logic [QW-1:0]   NegMax   = {1'b1, {(QW-1){1'b0}}};

    logic            r_busy;
    logic            r_fin;
    logic [CntW-1:0] r_cnt;
    logic [RW-1:0]   r_rem;
    logic [RW-1:0]   r_dsh;
    logic [QW-1:0]   r_q;
    logic            r_neg;
    logic            r_ovf;

    logic [RW:0]     w_diff;
    logic            w_ge;
    logic [QW-1:0]   w_quot;

    assign w_diff = {1'b0, r_rem} - {1'b0, r_dsh};
    assign w_ge   = !w_diff[RW];

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LastStep) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    // Datapath: one quotient bit per cycle, most significant first
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= {{(RW-NW){1'b0}}, i_req.num_mag};
            r_dsh <= {1'b0, i_req.den_mag, {(QW-1){1'b0}}};
            r_q   <= '0;
            r_neg <= i_req.neg;
            r_ovf <= {{(RW-NW){1'b0}}, i_req.num_mag} >= {i_req.den_mag, {QW{1'b0}}};
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= w_diff[RW-1:0];
            end
            r_q   <= {r_q[QW-2:0], w_ge};
            r_dsh <= {1'b0, r_dsh[RW-1:1]};
        end
    end

    always_comb begin
        if (!r_neg) begin
            w_quot = (r_ovf || r_q[QW-1]) ? PosMax : r_q;
        end else begin
            w_quot = (r_ovf || (r_q > NegMax)) ? NegMax : (~r_q + 1'b1);
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_fin;
    assign o_rsp.quot = $signed(w_quot);

endmodule

`default_nettype wire

[rtl/strip_charge_division_position_top.sv]
// Top level: charge division position calibration for resistive strips.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+-------------------------------------
//  cfg     | in        | i_cfg_we                    | i_cfg_data (energy threshold)
//  in      | in        | i_in_valid / o_in_ready     | i_req_type .. i_load_right_edge
//  out     | out       | o_out_valid / i_out_ready   | o_in_range .. o_divide_error
//
// A load word returns to ready after the lookup state; an out-of-range hit also
// passes the final state. A hit in range runs table read, multiply, sums, then two
// passes through the bit-serial divider, each a start state, 16 quotient bits and a
// done strobe. Zero energy ends after the sums, a zero edge span after the first pass.
// Reset clears the control state, the threshold (to 1000) and every table valid
// bit at once, so the table reads as zero until loaded; no clearing pass.
// A finished result sits in the output register while the next word is taken;
// the engine only waits in its final state if that register is still full.
`default_nettype none

module strip_charge_division_position_top #(
    parameter int NUM_DETECTORS = scd_pkg::NUM_DETECTORS_DEF,
    parameter int NUM_STRIPS    = scd_pkg::NUM_STRIPS_DEF,
    parameter int ADC_BITS      = scd_pkg::ADC_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,

    input  wire logic                              i_cfg_we,
    input  wire logic        [scd_pkg::THR_W-1:0]  i_cfg_data,

    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic                              i_req_type,
    input  wire logic                              i_side,
    input  wire logic        [scd_pkg::DET_W-1:0]  i_detector,
    input  wire logic        [scd_pkg::STRIP_W-1:0] i_strip,
    input  wire logic        [scd_pkg::ADC_W-1:0]  i_left_adc,
    input  wire logic        [scd_pkg::ADC_W-1:0]  i_right_adc,
    input  wire logic signed [scd_pkg::CAL_W-1:0]  i_load_gain,
    input  wire logic signed [scd_pkg::CAL_W-1:0]  i_load_left_edge,
    input  wire logic signed [scd_pkg::CAL_W-1:0]  i_load_right_edge,

    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic                                   o_in_range,
    output logic signed      [scd_pkg::ESUM_W-1:0] o_energy_sum,
    output logic signed      [scd_pkg::CAL_W-1:0]  o_raw_position,
    output logic signed      [scd_pkg::CAL_W-1:0]  o_cal_position,
    output logic                                   o_above_threshold,
    output logic                                   o_divide_error
);

    localparam int Depth   = 2 * NUM_DETECTORS * NUM_STRIPS;
    localparam int AddrW   = $clog2(Depth);
    localparam int AdcW    = scd_pkg::ADC_W;
    localparam int CalW    = scd_pkg::CAL_W;
    localparam int EntW    = scd_pkg::ENTRY_W;
    localparam int EsW     = scd_pkg::ESUM_W;
    localparam int ThrW    = scd_pkg::THR_W;
    localparam int NumW    = scd_pkg::DIV_NUM_W;
    localparam int DenW    = scd_pkg::DIV_DEN_W;
    localparam int AdcKeep = (ADC_BITS < AdcW) ? ADC_BITS : AdcW;
    localparam logic [AdcW-1:0] AdcMask = AdcW'((1 << AdcKeep) - 1);

    // Product and sum widths: right (unsigned) times gain Q4.12, left at Q.12
    localparam int RgW  = AdcW + 1 + CalW;   // signed product
    localparam int LqW  = AdcW + 12;         // left * 4096
    localparam int EpW  = RgW + 1;           // signed sum / difference
    localparam int FrW  = 14;                // Q2.14 scale for the dividends
    localparam int SpW  = CalW + 1;          // edge span and raw - left edge

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_LOOK   = 9'b000000010,
        S_MUL    = 9'b000000100,
        S_SUM    = 9'b000001000,
        S_START1 = 9'b000010000,
        S_DIV1   = 9'b000100000,
        S_START2 = 9'b001000000,
        S_DIV2   = 9'b010000000,
        S_FIN    = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [ThrW-1:0] r_thresh;
    logic [Depth-1:0] r_tab_valid;

    // Work registers
    logic                   r_hit;
    logic                   r_ok;
    logic [AddrW-1:0]       r_idx;
    logic [AdcW-1:0]        r_left;
    logic [AdcW-1:0]        r_right;
    logic [EntW-1:0]        r_wdata;
    logic                   r_rd_ok;
    logic signed [RgW-1:0]  r_rg;
    logic [LqW-1:0]         r_lq;
    logic signed [CalW-1:0] r_le;
    logic signed [CalW-1:0] r_re;
    logic signed [EpW-1:0]  r_ep;
    logic signed [EpW-1:0]  r_np;
    logic signed [SpW-1:0]  r_span;
    logic                   r_inrange;
    logic signed [EsW-1:0]  r_esum;
    logic signed [CalW-1:0] r_raw;
    logic signed [CalW-1:0] r_cal;
    logic                   r_above;
    logic                   r_derr;

    // Output register
    logic                   r_out_valid;
    logic                   r_o_inrange;
    logic signed [EsW-1:0]  r_o_esum;
    logic signed [CalW-1:0] r_o_raw;
    logic signed [CalW-1:0] r_o_cal;
    logic                   r_o_above;
    logic                   r_o_derr;

    logic                   w_in_acc;
    logic                   w_idx_ok;
    logic [AddrW-1:0]       w_idx;
    logic                   w_wr;
    logic                   w_rd;
    logic [EntW-1:0]        w_rdata;
    logic [EntW-1:0]        w_entry;
    logic                   w_out_load;
    logic signed [EsW:0]    w_es_t;
    logic signed [EsW-1:0]  w_es_sat;
    logic                   w_above;
    logic [EpW-1:0]         w_np_mag;
    logic [EpW-1:0]         w_ep_mag;
    logic signed [SpW-1:0]  w_d;
    logic [SpW-1:0]         w_d_mag;
    logic [SpW-1:0]         w_span_mag;
    logic                   w_ep_zero;
    logic                   w_span_zero;

    scd_pkg::t_div_req w_div_req;
    scd_pkg::t_div_rsp w_div_rsp;

    // ---------------------------------------------------------------------
    // Input decode: table index is side-major, then detector, then strip
    // ---------------------------------------------------------------------
    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_idx_ok   = (int'(i_detector) < NUM_DETECTORS) && (int'(i_strip) < NUM_STRIPS);
    assign w_idx      = AddrW'((int'(i_side) * NUM_DETECTORS + int'(i_detector)) * NUM_STRIPS
                               + int'(i_strip));

    // Loads write in the lookup state, hits read there; one word is in flight
    // at a time, so a write and a read of the same entry never overlap.
    assign w_wr = (r_state == S_LOOK) && !r_hit && r_ok;
    assign w_rd = (r_state == S_LOOK) && r_hit && r_ok;

    scd_ram #(
        .WIDTH (EntW),
        .DEPTH (Depth)
    ) u_cal_table (
        .i_clk   (i_clk),
        .i_we    (w_wr),
        .i_waddr (r_idx),
        .i_wdata (r_wdata),
        .i_re    (w_rd),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    // An entry never loaded since reset reads as all zero
    assign w_entry = r_rd_ok ? w_rdata : '0;

    // ---------------------------------------------------------------------
    // Energy in ADC units: truncate toward zero, then saturate to 17 bits
    // ---------------------------------------------------------------------
    assign w_es_t = $signed(r_ep[EpW-1:12])
                  + $signed({{EsW{1'b0}}, (r_ep[EpW-1] && (|r_ep[11:0]))});

    always_comb begin
        if (w_es_t[EsW] != w_es_t[EsW-1]) begin
            w_es_sat = w_es_t[EsW] ? {1'b1, {(EsW-1){1'b0}}} : {1'b0, {(EsW-1){1'b1}}};
        end else begin
            w_es_sat = w_es_t[EsW-1:0];
        end
    end

    assign w_above = $signed({w_es_sat[EsW-1], w_es_sat}) >= $signed({2'b00, r_thresh});

    assign w_ep_zero   = (r_ep == '0);
    assign w_span_zero = (r_span == '0);
    assign w_np_mag    = r_np[EpW-1] ? (~r_np + 1'b1) : r_np;
    assign w_ep_mag    = r_ep[EpW-1] ? (~r_ep + 1'b1) : r_ep;
    assign w_d         = {r_raw[CalW-1], r_raw} - {r_le[CalW-1], r_le};
    assign w_d_mag     = w_d[SpW-1] ? (~w_d + 1'b1) : w_d;
    assign w_span_mag  = r_span[SpW-1] ? (~r_span + 1'b1) : r_span;

    // Divider requests: raw = np*2^14/ep, then cal = (raw - left)*2^14/span
    always_comb begin
        w_div_req = '0;
        if (r_state == S_START1) begin
            w_div_req.start   = !w_ep_zero;
            w_div_req.neg     = r_np[EpW-1] ^ r_ep[EpW-1];
            w_div_req.num_mag = NumW'({w_np_mag, {FrW{1'b0}}});
            w_div_req.den_mag = DenW'(w_ep_mag);
        end else if (r_state == S_START2) begin
            w_div_req.start   = !w_span_zero;
            w_div_req.neg     = w_d[SpW-1] ^ r_span[SpW-1];
            w_div_req.num_mag = {{(NumW-SpW-FrW){1'b0}}, w_d_mag, {FrW{1'b0}}};
            w_div_req.den_mag = {{(DenW-SpW){1'b0}}, w_span_mag};
        end
    end

    scd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    assign w_out_load = (r_state == S_FIN) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (!r_hit) begin
                    n_state = S_IDLE;
                end else if (!r_ok) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL:    n_state = S_SUM;
            S_SUM:    n_state = S_START1;
            S_START1: n_state = w_ep_zero ? S_FIN : S_DIV1;
            S_DIV1: begin
                if (w_div_rsp.done) begin
                    n_state = S_START2;
                end
            end
            S_START2: n_state = w_span_zero ? S_FIN : S_DIV2;
            S_DIV2: begin
                if (w_div_rsp.done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_thresh    <= scd_pkg::THRESH_RESET;
            r_tab_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_thresh <= i_cfg_data;
            end
            if (w_wr) begin
                r_tab_valid[r_idx] <= 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_hit   <= (i_req_type == scd_pkg::REQ_HIT);
            r_ok    <= w_idx_ok;
            r_idx   <= w_idx;
            r_left  <= i_left_adc & AdcMask;
            r_right <= i_right_adc & AdcMask;
            r_wdata <= {i_load_gain, i_load_left_edge, i_load_right_edge};
        end

        unique case (r_state)
            S_LOOK: begin
                // Start every hit from a clean result; out of range stays all zero
                r_rd_ok   <= r_tab_valid[r_idx];
                r_inrange <= r_ok;
                r_esum    <= '0;
                r_raw     <= '0;
                r_cal     <= '0;
                r_above   <= 1'b0;
                r_derr    <= 1'b0;
            end
            S_MUL: begin
                r_rg <= RgW'($signed({1'b0, r_right}))
                      * RgW'($signed(w_entry[EntW-1 -: CalW]));
                r_lq <= {r_left, 12'b0};
                r_le <= $signed(w_entry[2*CalW-1 -: CalW]);
                r_re <= $signed(w_entry[CalW-1:0]);
            end
            S_SUM: begin
                r_ep   <= {r_rg[RgW-1], r_rg} + $signed({{(EpW-LqW){1'b0}}, r_lq});
                r_np   <= {r_rg[RgW-1], r_rg} - $signed({{(EpW-LqW){1'b0}}, r_lq});
                r_span <= {r_re[CalW-1], r_re} - {r_le[CalW-1], r_le};
            end
            S_START1: begin
                r_esum  <= w_es_sat;
                r_above <= w_above;
                if (w_ep_zero) begin
                    r_derr <= 1'b1;
                end
            end
            S_DIV1: begin
                if (w_div_rsp.done) begin
                    r_raw <= w_div_rsp.quot;
                end
            end
            S_START2: begin
                if (w_span_zero) begin
                    r_derr <= 1'b1;
                end
            end
            S_DIV2: begin
                if (w_div_rsp.done) begin
                    r_cal <= w_div_rsp.quot;
                end
            end
            default: begin
            end
        endcase

        if (w_out_load) begin
            r_o_inrange <= r_inrange;
            r_o_esum    <= r_esum;
            r_o_raw     <= r_raw;
            r_o_cal     <= r_cal;
            r_o_above   <= r_above;
            r_o_derr    <= r_derr;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_in_range        = r_o_inrange;
    assign o_energy_sum      = r_o_esum;
    assign o_raw_position    = r_o_raw;
    assign o_cal_position    = r_o_cal;
    assign o_above_threshold = r_o_above;
    assign o_divide_error    = r_o_derr;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_div_idle_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_div_rsp.busy && !w_div_rsp.done)
        else $error("divider active while a new word can be taken");

    a_div_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_DIV1) || (r_state == S_DIV2))
        else $error("divider finished outside a divide wait state");

    a_derr_zero_cal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_divide_error) |-> (o_cal_position == '0))
        else $error("divide error word with nonzero calibrated position");

    a_out_of_range_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_in_range) |-> (o_energy_sum == '0) && !o_divide_error
                                          && !o_above_threshold)
        else $error("out of range word carries nonzero fields");

endmodule

`default_nettype wire
